### rtl/core/vlads_pkg.sv
package vlads_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int VALUE_BITS  = 16;

   // Field widths of the request and response beats
   localparam int ITEM_W   = 16;
   localparam int STATUS_W = 2;
   localparam int SUM_W    = 21;
   localparam int CNT_W    = 6;
   localparam int MEAN_W   = 23;

   // Mean scaling and divider sizing
   localparam int MEAN_SCALE = 100;
   localparam int NUM_W      = 28;
   localparam int STEP_W     = $clog2(NUM_W);

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Operation broadcast to every cell of the table
   typedef struct packed {
      op_type                kind;
      logic [VALUE_BITS-1:0] value;
   } cell_cmd_type;

endpackage

### rtl/core/vlads_if.sv
interface vlads_req_if;
   import vlads_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ITEM_W-1:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface vlads_rsp_if;
   import vlads_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SUM_W-1:0]    total_sum;
   logic [CNT_W-1:0]    entry_count;
   logic [MEAN_W-1:0]   mean_x100;
   logic                is_empty;

   modport source (output valid, output status, output total_sum, output entry_count,
                   output mean_x100, output is_empty, input ready);
   modport sink   (input valid, input status, input total_sum, input entry_count,
                   input mean_x100, input is_empty, output ready);
endinterface

### rtl/core/vlads_cell.sv
module vlads_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  vlads_pkg::cell_cmd_type cmd,
   input  logic                   tok_prev,
   output logic                   tok_next,
   output logic                   hit
);
   import vlads_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  tok_ff;
   logic                  tok_in;
   logic                  match;

   // Claim a free slot on append, or free a matching slot on delete
   always_comb begin
      if (cmd.kind == OP_APPEND) begin
         match = !valid_ff;
      end else begin
         match = valid_ff && (value_ff == cmd.value);
      end
      hit      = tok_prev && match;
      tok_in   = tok_prev && !match;
      valid_in = hit ? (cmd.kind == OP_APPEND) : valid_ff;
   end

   assign tok_next = tok_ff;

   // Hand the search token to the next cell when this one does not take it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   // Store the value on a claimed append
   always_ff @(posedge clock) begin
      if (hit && (cmd.kind == OP_APPEND)) begin
         value_ff <= cmd.value;
      end
   end

endmodule

### rtl/core/vlads_div.sv
module vlads_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [vlads_pkg::NUM_W-1:0] num,
   input  logic [vlads_pkg::CNT_W-1:0] den,
   output logic                      done,
   output logic [vlads_pkg::MEAN_W-1:0] quo
);
   import vlads_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [NUM_W-1:0]  quo_ff;
   logic [CNT_W:0]    trial;
   logic              ge;

   // One restoring step: shift in the next numerator bit and try the subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      ge     = trial >= {1'b0, den};
      rem_in = ge ? CNT_W'(trial - {1'b0, den}) : CNT_W'(trial);
   end

   // Sequence the steps, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(NUM_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Quotient bits replace numerator bits in one shift register
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff[MEAN_W-1:0];

endmodule

### rtl/core/value_list_append_delete_stats.sv
// Flow from the accepting edge to the response beat: token scan, load, 28 divider
// steps and their done flag, send. The divider is skipped when the table is empty.
// One request at a time: the next is taken once the previous result sits in the
// response register.
// Reset (synchronous, active high) clears all slots, the sum, the count and the state.
module value_list_append_delete_stats (
   input  logic        clock,
   input  logic        reset,
   vlads_req_if.sink   req_chan,
   vlads_rsp_if.source rsp_chan
);
   import vlads_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_LOAD = 5'b00100,
      S_DIV  = 5'b01000,
      S_SEND = 5'b10000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   cell_cmd_type         cmd_ff;
   logic                 start_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     count_ff;
   status_type           status_ff;
   logic [MEAN_W-1:0]    mean_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic [MEAN_W-1:0]    rsp_mean_ff;
   logic                 rsp_empty_ff;
   logic [TABLE_DEPTH:0] tok;
   logic [TABLE_DEPTH-1:0] hit;
   logic                 hit_any;
   logic                 accept;
   logic                 send;
   logic                 div_start;
   logic                 div_done;
   logic [NUM_W-1:0]     div_num;
   logic [MEAN_W-1:0]    div_quo;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign send           = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_chan.ready);
   assign div_start      = (state_ff == S_LOAD) && (count_ff != '0);
   assign hit_any        = |hit;
   assign div_num        = NUM_W'(sum_ff) * NUM_W'(MEAN_SCALE) + NUM_W'(count_ff >> 1);

   // Row of table cells; the search token enters at slot 0
   assign tok[0] = start_ff;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      vlads_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .tok_prev (tok[i]),
         .tok_next (tok[i+1]),
         .hit      (hit[i])
      );
   end

   vlads_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (count_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_SCAN;
         S_SCAN: if (hit_any || tok[TABLE_DEPTH]) state_in = S_LOAD;
         S_LOAD: state_in = (count_ff != '0) ? S_DIV : S_SEND;
         S_DIV:  if (div_done) state_in = S_SEND;
         S_SEND: if (send) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and running totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         if ((state_ff == S_SCAN) && hit_any) begin
            if (cmd_ff.kind == OP_APPEND) begin
               sum_ff   <= sum_ff + SUM_W'(cmd_ff.value);
               count_ff <= count_ff + 1'b1;
            end else begin
               sum_ff   <= sum_ff - SUM_W'(cmd_ff.value);
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   // Latch the request, the outcome and the mean
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.kind  <= op_type'(req_chan.req_type);
         cmd_ff.value <= req_chan.item_value[VALUE_BITS-1:0];
      end
      if (state_ff == S_SCAN) begin
         if (hit_any) begin
            status_ff <= STATUS_DONE;
         end else if (tok[TABLE_DEPTH]) begin
            status_ff <= (cmd_ff.kind == OP_APPEND) ? STATUS_FULL : STATUS_NOT_FOUND;
         end
      end
      if ((state_ff == S_LOAD) && (count_ff == '0)) begin
         mean_ff <= '0;
      end else if ((state_ff == S_DIV) && div_done) begin
         mean_ff <= div_quo;
      end
   end

   // Response register: hold the beat until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         rsp_status_ff <= status_ff;
         rsp_sum_ff    <= sum_ff;
         rsp_count_ff  <= count_ff;
         rsp_mean_ff   <= mean_ff;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.total_sum   = rsp_sum_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.mean_x100   = rsp_mean_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;

endmodule
